[src/max_pool_2d_stream_assert.svh]
// Assertion macros for the max pooling stream.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef MAX_POOL_2D_STREAM_ASSERT_SVH
`define MAX_POOL_2D_STREAM_ASSERT_SVH

// Condition holds at every edge out of reset.
`define MP2D_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define MP2D_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define MP2D_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/mp2d_pkg.sv]
package mp2d_pkg;

    localparam int SAMPLE_W = 16;
    typedef logic signed [SAMPLE_W-1:0] sample_t;
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 11;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

    localparam cfg_index_t CFG_CHANNELS     = 3'd0;
    localparam cfg_index_t CFG_IMAGE_HEIGHT = 3'd1;
    localparam cfg_index_t CFG_IMAGE_WIDTH  = 3'd2;
    localparam cfg_index_t CFG_POOL_HEIGHT  = 3'd3;
    localparam cfg_index_t CFG_POOL_WIDTH   = 3'd4;
    localparam cfg_index_t CFG_POOL_STRIDE  = 3'd5;

    localparam int CH_RAW_W   = 9;
    localparam int DIM_RAW_W  = 11;
    localparam int POOL_RAW_W = 4;
    localparam int STRIDE_W   = 4;
    typedef logic [STRIDE_W-1:0] stride_t;

    // Signed maximum of two samples.
    function automatic sample_t smax(input sample_t a, input sample_t b);
        return (a > b) ? a : b;
    endfunction

endpackage

[src/mp2d_row_max.sv]
// Shift line over the newest samples of a row and a max tree over the
// first pool_width taps.
module mp2d_row_max #(
    parameter int MAX_POOL = 8,
    parameter int PW_W     = $clog2(MAX_POOL + 1)
) (
    input  logic              clk,
    input  logic              shift_en,
    input  mp2d_pkg::sample_t sample_in,
    input  logic [PW_W-1:0]   pool_width,
    output mp2d_pkg::sample_t row_max
);
    import mp2d_pkg::*;

    localparam int LV     = $clog2(MAX_POOL);
    localparam int LEAVES = 1 << LV;

    sample_t taps_reg [MAX_POOL];
    sample_t node     [LV+1][LEAVES];

    // Tap 0 holds the newest sample.
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            taps_reg[0] <= sample_in;
            for (int k = 1; k < MAX_POOL; k++)
            begin
                taps_reg[k] <= taps_reg[k-1];
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l <= LV; l++)
        begin
            for (int j = 0; j < LEAVES; j++)
            begin
                node[l][j] = SAMPLE_MIN;
            end
        end
        for (int j = 0; j < MAX_POOL; j++)
        begin
            if (PW_W'(j) < pool_width)
            begin
                node[0][j] = taps_reg[j];
            end
        end
        for (int l = 0; l < LV; l++)
        begin
            for (int j = 0; j < LEAVES / 2; j++)
            begin
                node[l+1][j] = smax(node[l][2*j], node[l][2*j+1]);
            end
        end
    end

    assign row_max = node[LV][0];

endmodule

[src/mp2d_acc_ram.sv]
// Column accumulator memory: one lane per row slot, one entry per column.
// Read data is registered; a write to the address being read in the same
// cycle is forwarded.
module mp2d_acc_ram #(
    parameter int DEPTH = 1024,
    parameter int LANES = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [AW-1:0]                 rd_addr,
    output mp2d_pkg::sample_t [LANES-1:0] rd_data,
    input  logic                          wr_en,
    input  logic [AW-1:0]                 wr_addr,
    input  mp2d_pkg::sample_t [LANES-1:0] wr_data
);
    import mp2d_pkg::*;

    sample_t [LANES-1:0] mem [DEPTH];
    sample_t [LANES-1:0] mem_q_reg;
    sample_t [LANES-1:0] fwd_data_reg;
    logic                fwd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg    <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : mem_q_reg;

endmodule

[src/max_pool_2d_stream.sv]
// A pooled value passes from its sample beat through the stage-1 registers and the
// output register to the result port, where it can be taken.
// Throughput: one sample per cycle, set by the single accumulator memory read per beat.
// The sample channel stalls only while a result waits in the output register and
// another one is ready behind it.
// Reset: asynchronous, clears counters, pipeline and output valid, loads default registers;
// the accumulator memory is not cleared (no clearing pass).
`include "max_pool_2d_stream_assert.svh"

module max_pool_2d_stream #(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_HEIGHT   = 1024,
    parameter int MAX_CHANNELS = 256,
    parameter int MAX_POOL     = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // sample channel
    input  logic                   sample_valid,
    output logic                   sample_stall,
    input  mp2d_pkg::sample_t      sample,
    // result channel
    output logic                   result_valid,
    input  logic                   result_stall,
    output mp2d_pkg::sample_t      pooled_value,
    output logic                   final_flag,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  mp2d_pkg::cfg_index_t   cfg_index,
    input  mp2d_pkg::cfg_data_t    cfg_data
);
    import mp2d_pkg::*;

    // Widths of counters and clamped register values.
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int NWW   = $clog2(MAX_WIDTH + 1);
    localparam int NHW   = $clog2(MAX_HEIGHT + 1);
    localparam int NCW   = $clog2(MAX_CHANNELS + 1);
    localparam int PHW   = $clog2(MAX_POOL + 1);
    localparam int SW    = $clog2(MAX_POOL);
    localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    // Wide enough for a counter plus one plus the largest stride.
    localparam int CMP_W = $clog2(MAX_DIM) + 2;

    // Clamp a register value to 1..hi.
    function automatic logic [15:0] clamp_dim(input logic [15:0] v, input logic [15:0] hi);
        logic [15:0] r;
        if (v == 16'd0)
        begin
            r = 16'd1;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers, held clamped.
    // ------------------------------------------------------------------
    logic [NCW-1:0] nc_reg, nc_next;
    logic [NHW-1:0] nh_reg, nh_next;
    logic [NWW-1:0] nw_reg, nw_next;
    logic [PHW-1:0] ph_reg, ph_next;
    logic [PHW-1:0] pw_reg, pw_next;
    stride_t        st_reg, st_next;
    logic           restart;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        nc_next = nc_reg;
        nh_next = nh_reg;
        nw_next = nw_reg;
        ph_next = ph_reg;
        pw_next = pw_reg;
        st_next = st_reg;
        restart = 1'b0;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CHANNELS:
                begin
                    nc_next = NCW'(clamp_dim(16'(cfg_data[CH_RAW_W-1:0]),
                                             16'(MAX_CHANNELS)));
                    restart = 1'b1;
                end
                CFG_IMAGE_HEIGHT:
                begin
                    nh_next = NHW'(clamp_dim(16'(cfg_data[DIM_RAW_W-1:0]),
                                             16'(MAX_HEIGHT)));
                    restart = 1'b1;
                end
                CFG_IMAGE_WIDTH:
                begin
                    nw_next = NWW'(clamp_dim(16'(cfg_data[DIM_RAW_W-1:0]),
                                             16'(MAX_WIDTH)));
                    restart = 1'b1;
                end
                CFG_POOL_HEIGHT:
                begin
                    ph_next = PHW'(clamp_dim(16'(cfg_data[POOL_RAW_W-1:0]),
                                             16'(MAX_POOL)));
                    restart = 1'b1;
                end
                CFG_POOL_WIDTH:
                begin
                    pw_next = PHW'(clamp_dim(16'(cfg_data[POOL_RAW_W-1:0]),
                                             16'(MAX_POOL)));
                    restart = 1'b1;
                end
                CFG_POOL_STRIDE:
                begin
                    st_next = (cfg_data[STRIDE_W-1:0] == '0) ? stride_t'(1)
                                                             : cfg_data[STRIDE_W-1:0];
                    restart = 1'b1;
                end
                default:
                begin
                    // Drop writes beyond the register list.
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nc_reg <= NCW'(1);
            nh_reg <= NHW'(1);
            nw_reg <= NWW'(1);
            ph_reg <= PHW'(2);
            pw_reg <= PHW'(2);
            st_reg <= stride_t'(2);
        end
        else
        begin
            nc_reg <= nc_next;
            nh_reg <= nh_next;
            nw_reg <= nw_next;
            ph_reg <= ph_next;
            pw_reg <= pw_next;
            st_reg <= st_next;
        end
    end

    // ------------------------------------------------------------------
    // Handshake and stage-1 advance.
    // Stage 1 holds only when it carries a result and the output register
    // is full and stalled.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s1_emit_reg;
    logic s1_last_reg;
    logic [CW-1:0] s1_col_reg;
    logic [SW-1:0] s1_row_slot_reg;
    logic [SW-1:0] s1_out_slot_reg;
    logic s1_move;
    logic accept;

    assign s1_move      = s1_valid_reg && !(s1_emit_reg && result_valid && result_stall);
    assign sample_stall = s1_valid_reg && !s1_move;
    assign accept       = sample_valid && !sample_stall;

    // ------------------------------------------------------------------
    // Position counters. The phase counters track the window origin modulo
    // the stride, so no divider is needed.
    // ------------------------------------------------------------------
    logic [CW-1:0]  col_count_reg, col_count_next;
    logic [RW-1:0]  row_count_reg, row_count_next;
    logic [CHW-1:0] ch_count_reg,  ch_count_next;
    logic [SW-1:0]  row_slot_reg,  row_slot_next;
    stride_t        col_phase_reg, col_phase_next;
    stride_t        row_phase_reg, row_phase_next;

    logic col_last, row_last, ch_last;
    logic col_open, row_open;
    logic emit_c, last_c;
    logic [SW:0]   slot_sum;
    logic [SW-1:0] out_slot_c;

    always_comb
    begin
        col_last = (CMP_W'(col_count_reg) + CMP_W'(1)) == CMP_W'(nw_reg);
        row_last = (CMP_W'(row_count_reg) + CMP_W'(1)) == CMP_W'(nh_reg);
        ch_last  = (NCW'(ch_count_reg) + NCW'(1)) == nc_reg;
        // A window can end at this sample once enough columns and rows are in.
        col_open = (CMP_W'(col_count_reg) + CMP_W'(1)) >= CMP_W'(pw_reg);
        row_open = (CMP_W'(row_count_reg) + CMP_W'(1)) >= CMP_W'(ph_reg);
        emit_c   = col_open && row_open && (col_phase_reg == '0) && (row_phase_reg == '0);
        // Last window of the channel in both directions, last channel of the tensor.
        last_c   = ch_last
                && ((CMP_W'(row_count_reg) + CMP_W'(1) + CMP_W'(st_reg)) > CMP_W'(nh_reg))
                && ((CMP_W'(col_count_reg) + CMP_W'(1) + CMP_W'(st_reg)) > CMP_W'(nw_reg));
        // Row slot of the window origin: current slot minus (pool_height - 1), wrapped.
        slot_sum = (SW+1)'(row_slot_reg) + (SW+1)'(MAX_POOL + 1) - (SW+1)'(ph_reg);
        if (slot_sum >= (SW+1)'(MAX_POOL))
        begin
            slot_sum = slot_sum - (SW+1)'(MAX_POOL);
        end
        out_slot_c = slot_sum[SW-1:0];
    end

    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        ch_count_next  = ch_count_reg;
        row_slot_next  = row_slot_reg;
        col_phase_next = col_phase_reg;
        row_phase_next = row_phase_reg;
        if (restart)
        begin
            col_count_next = '0;
            row_count_next = '0;
            ch_count_next  = '0;
            row_slot_next  = '0;
            col_phase_next = '0;
            row_phase_next = '0;
        end
        else if (accept)
        begin
            if (col_last)
            begin
                col_count_next = '0;
                col_phase_next = '0;
                if (row_last)
                begin
                    row_count_next = '0;
                    row_slot_next  = '0;
                    row_phase_next = '0;
                    ch_count_next  = ch_last ? '0 : ch_count_reg + CHW'(1);
                end
                else
                begin
                    row_count_next = row_count_reg + RW'(1);
                    row_slot_next  = (row_slot_reg == SW'(MAX_POOL - 1))
                                   ? '0 : row_slot_reg + SW'(1);
                    if (row_open)
                    begin
                        row_phase_next = (row_phase_reg + stride_t'(1) == st_reg)
                                       ? '0 : row_phase_reg + stride_t'(1);
                    end
                end
            end
            else
            begin
                col_count_next = col_count_reg + CW'(1);
                if (col_open)
                begin
                    col_phase_next = (col_phase_reg + stride_t'(1) == st_reg)
                                   ? '0 : col_phase_reg + stride_t'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            ch_count_reg  <= '0;
            row_slot_reg  <= '0;
            col_phase_reg <= '0;
            row_phase_reg <= '0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            ch_count_reg  <= ch_count_next;
            row_slot_reg  <= row_slot_next;
            col_phase_reg <= col_phase_next;
            row_phase_reg <= row_phase_next;
        end
    end

    // ------------------------------------------------------------------
    // Horizontal max: shift the sample in on every beat; in stage 1 the
    // tree gives the max of the last pool_width samples of the row.
    // ------------------------------------------------------------------
    sample_t row_max;

    mp2d_row_max #(
        .MAX_POOL (MAX_POOL),
        .PW_W     (PHW)
    ) u_row_max (
        .clk        (clk),
        .shift_en   (accept),
        .sample_in  (sample),
        .pool_width (pw_reg),
        .row_max    (row_max)
    );

    // ------------------------------------------------------------------
    // Column accumulators: for each column, one lane per row slot holds the
    // max over rows from that slot's row down to the current row. Read on
    // the beat, modify in stage 1, write back when stage 1 advances.
    // ------------------------------------------------------------------
    sample_t [MAX_POOL-1:0] acc_old;
    sample_t [MAX_POOL-1:0] acc_new;
    sample_t                window_max;

    mp2d_acc_ram #(
        .DEPTH (MAX_WIDTH),
        .LANES (MAX_POOL),
        .AW    (CW)
    ) u_acc_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (col_count_reg),
        .rd_data (acc_old),
        .wr_en   (s1_move),
        .wr_addr (s1_col_reg),
        .wr_data (acc_new)
    );

    always_comb
    begin
        for (int k = 0; k < MAX_POOL; k++)
        begin
            // Start the lane of the current row, fold the row max into the rest.
            if (SW'(k) == s1_row_slot_reg)
            begin
                acc_new[k] = row_max;
            end
            else
            begin
                acc_new[k] = smax(acc_old[k], row_max);
            end
        end
        window_max = acc_new[s1_out_slot_reg];
    end

    // Stage-1 context.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg      <= col_count_reg;
            s1_row_slot_reg <= row_slot_reg;
            s1_out_slot_reg <= out_slot_c;
            s1_emit_reg     <= emit_c;
            s1_last_reg     <= last_c;
        end
    end

    // ------------------------------------------------------------------
    // Output register: load a window max when stage 1 advances with a
    // result, drop the beat once taken.
    // ------------------------------------------------------------------
    logic    result_valid_reg;
    sample_t pooled_value_reg;
    logic    final_flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (s1_move && s1_emit_reg)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && s1_emit_reg)
        begin
            pooled_value_reg <= window_max;
            final_flag_reg   <= s1_last_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign pooled_value = pooled_value_reg;
    assign final_flag   = final_flag_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    logic counters_ok;
    logic tall_pool;
    logic slot_clash;
    logic load_result;

    assign counters_ok = (CMP_W'(col_count_reg) < CMP_W'(nw_reg))
                      && (CMP_W'(row_count_reg) < CMP_W'(nh_reg))
                      && (NCW'(ch_count_reg) < nc_reg);
    assign tall_pool   = ph_reg != PHW'(1);
    assign slot_clash  = out_slot_c == row_slot_reg;
    assign load_result = s1_move && s1_emit_reg;

    `MP2D_ASSERT_ALWAYS(a_counters_in_range, counters_ok, "position counter out of range")
    `MP2D_ASSERT_SAME(a_origin_slot_distinct, tall_pool, !slot_clash, "origin slot clash")
    `MP2D_ASSERT_NEXT(a_result_loaded, load_result, result_valid_reg, "result lost")

endmodule
